FILE: rtl/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared constants and types for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

  // Width of the binary input and number of decimal digit cells.
  localparam int unsigned MagWidth  = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned CntWidth  = $clog2(MagWidth);
  localparam int unsigned RemWidth  = $clog2(NumDigits + 1);

  // ASCII codes.
  localparam logic [7:0] CharMinus = 8'd45;
  localparam logic [7:0] CharZero  = 8'd48;

  // Double-dabble correction: a digit of five or more gets three added.
  localparam logic [3:0] AdjThresh = 4'd5;
  localparam logic [3:0] AdjAdd    = 4'd3;

  // Control word that drives every cell of the chain.
  typedef struct packed {
    logic clear;        // Zero all digits.
    logic shift_bit;    // Adjust and shift in one binary bit.
    logic shift_digit;  // Move each digit one cell up.
  } chain_ctrl_t;

endpackage

FILE: rtl/signed_int_to_decimal_ascii_top.sv
// A '-' strobes in the cycle after the accepting edge when the number is
// negative; the digits follow once all magnitude bits are in the chain.
// The block stays busy after the accepting cycle through the 32 bit-serial
// steps of the digit chain and one readout step per digit cell (10).
// Reset: asynchronous and active low; the block comes up idle with no strobe.
// The receiver cannot stall: every character is strobed for exactly one cycle.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts a signed 32-bit integer into its decimal ASCII text, one character
// per strobe, with the final character flagged.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value_i,
  output logic        char_valid_o,
  output logic [7:0]  char_code_o,
  output logic        last_char_o
);
  import sitoa_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StDigits
  } state_e;

  state_e                state_q;
  logic [MagWidth-1:0]   mag_q;
  logic [CntWidth-1:0]   cnt_q;
  logic [RemWidth-1:0]   rem_q;
  logic                  started_q;
  logic                  valid_q;
  logic [7:0]            char_q;
  logic                  last_q;

  chain_ctrl_t           ctrl;
  logic [3:0]            top_digit;
  logic                  accept;
  logic                  negative;
  logic [MagWidth-1:0]   mag_abs;
  logic                  skip;

  assign accept   = start && (state_q == StIdle);
  assign negative = value_i[MagWidth-1];
  assign mag_abs  = negative ? (~value_i + 1'b1) : value_i;

  // A leading zero is dropped unless it is the only digit left.
  assign skip = !started_q && (top_digit == 4'd0) && (rem_q != RemWidth'(1));

  // Chain control.
  always_comb begin
    ctrl.clear       = accept;
    ctrl.shift_bit   = (state_q == StConv);
    ctrl.shift_digit = (state_q == StDigits);
  end

  sitoa_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .bit_i       (mag_q[MagWidth-1]),
    .top_digit_o (top_digit)
  );

  // Sequencer and registered character output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      rem_q     <= '0;
      started_q <= 1'b0;
      valid_q   <= 1'b0;
      char_q    <= '0;
      last_q    <= 1'b0;
      mag_q     <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            mag_q     <= mag_abs;
            cnt_q     <= '0;
            rem_q     <= RemWidth'(NumDigits);
            started_q <= 1'b0;
            state_q   <= StConv;
            if (negative) begin
              valid_q <= 1'b1;
              char_q  <= CharMinus;
              last_q  <= 1'b0;
            end
          end
        end
        StConv: begin
          mag_q <= {mag_q[MagWidth-2:0], 1'b0};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntWidth'(MagWidth - 1)) begin
            state_q <= StDigits;
          end
        end
        StDigits: begin
          rem_q <= rem_q - 1'b1;
          if (!skip) begin
            started_q <= 1'b1;
            valid_q   <= 1'b1;
            char_q    <= CharZero + {4'b0000, top_digit};
            last_q    <= (rem_q == RemWidth'(1));
          end
          if (rem_q == RemWidth'(1)) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy         = (state_q != StIdle);
  assign char_valid_o = valid_q;
  assign char_code_o  = char_q;
  assign last_char_o  = last_q;

endmodule

FILE: rtl/sitoa_cell.sv
// ----------------------------------------------------------------------------
// sitoa_cell
// One BCD digit of the conversion chain. It runs the add-three-and-shift step
// of binary to BCD conversion, or passes its digit to the next cell up.
// ----------------------------------------------------------------------------
module sitoa_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sitoa_pkg::chain_ctrl_t ctrl_i,
  input  logic                  bit_i,
  input  logic [3:0]            digit_i,
  output logic                  bit_o,
  output logic [3:0]            digit_o
);
  import sitoa_pkg::*;

  logic [3:0] digit_q;
  logic [3:0] digit_d;
  logic [3:0] adj;

  // Correct the digit so that the following shift carries properly.
  always_comb begin
    adj = (digit_q >= AdjThresh) ? (digit_q + AdjAdd) : digit_q;
  end

  assign bit_o   = adj[3];
  assign digit_o = digit_q;

  // Next digit value; the digit holds while the chain is idle.
  always_comb begin
    digit_d = digit_q;
    priority if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift_bit) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctrl_i.shift_digit) begin
      digit_d = digit_i;
    end else begin
      digit_d = digit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

FILE: rtl/sitoa_chain.sv
// ----------------------------------------------------------------------------
// sitoa_chain
// Row of BCD digit cells. Binary bits enter at the least significant cell;
// carries and digits travel toward the most significant cell.
// ----------------------------------------------------------------------------
module sitoa_chain (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sitoa_pkg::chain_ctrl_t ctrl_i,
  input  logic                   bit_i,
  output logic [3:0]             top_digit_o
);
  import sitoa_pkg::*;

  logic [NumDigits:0] carry;
  logic [3:0]         digit [NumDigits];
  logic [3:0]         digit_in [NumDigits];

  assign carry[0] = bit_i;

  // Each cell takes the carry and digit of the cell below it.
  for (genvar g = 0; g < NumDigits; g++) begin : g_cell
    if (g == 0) begin : g_low
      assign digit_in[g] = '0;
    end else begin : g_up
      assign digit_in[g] = digit[g-1];
    end

    sitoa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_i),
      .bit_i   (carry[g]),
      .digit_i (digit_in[g]),
      .bit_o   (carry[g+1]),
      .digit_o (digit[g])
    );
  end

  // The carry out of the top cell is always zero for a 32-bit magnitude.
  logic unused_carry;
  assign unused_carry = carry[NumDigits];

  assign top_digit_o = digit[NumDigits-1];

endmodule

FILE: test/signed_int_to_decimal_ascii_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top_tb
// Self-checking bench for the signed integer to decimal text converter. It
// sends a directed set of numbers (zero, the extremes, digit-count boundaries)
// and then random numbers with random idle bursts. It predicts each number's
// character string and checks every strobed character in order.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top_tb;
  import sitoa_pkg::*;

  localparam int unsigned NumRandom = 500;
  localparam int unsigned QuietTail = 80;
  localparam int unsigned SettleCycles = 60;

  // One expected character of the decimal text.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  // One number waiting to be sent, with the idle time in front of it.
  typedef struct {
    logic [31:0] value;
    int unsigned gap;
    bit          drain_first;
  } number_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [31:0] value_i = '0;
  logic        busy;
  logic        char_valid_o;
  logic [7:0]  char_code_o;
  logic        last_char_o;

  number_item_t number_q [$];
  text_char_t   expected_chars_q [$];
  int unsigned  total_numbers;
  int unsigned  sent_count = 0;
  int unsigned  chars_pending = 0;
  int unsigned  error_count = 0;
  int unsigned  gap_left = 0;
  bit           took;
  text_char_t   want;

  signed_int_to_decimal_ascii_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .value_i      (value_i),
    .char_valid_o (char_valid_o),
    .char_code_o  (char_code_o),
    .last_char_o  (last_char_o)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Queue up the characters the block must produce for one number.
  function automatic void push_decimal_text(input logic [31:0] number);
    logic [31:0] magnitude;
    logic [3:0]  digit_buf [NumDigits];
    int          count;
    text_char_t  ch;
    // The negation wraps, so the most negative value keeps its full magnitude.
    magnitude = number[31] ? (32'd0 - number) : number;
    count = 0;
    do begin
      digit_buf[count] = 4'(magnitude % 32'd10);
      magnitude = magnitude / 32'd10;
      count++;
    end while (magnitude != 0 && count < NumDigits);
    if (number[31]) begin
      ch.code = CharMinus;
      ch.last = 1'b0;
      expected_chars_q.push_back(ch);
    end
    for (int d = count - 1; d >= 0; d--) begin
      ch.code = CharZero + 8'(digit_buf[d]);
      ch.last = (d == 0);
      expected_chars_q.push_back(ch);
    end
  endfunction

  // Driver: presents numbers from the queue, honoring idle gaps and the
  // occasional wait for the block to drain completely. A gap counts only
  // once the block is idle, so it shows up as real idle time on the input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      value_i    <= '0;
      sent_count <= 0;
      gap_left = 0;
    end else begin
      took = start && !busy;
      if (took) begin
        sent_count <= sent_count + 1;
      end
      if (took && number_q.size() != 0) begin
        gap_left = number_q[0].gap;
      end else if (!start && !busy && gap_left != 0) begin
        gap_left = gap_left - 1;
      end
      if (start && !took) begin
        // Hold the current transaction until the block takes it.
      end else if (number_q.size() == 0 || gap_left != 0 ||
                   (number_q[0].drain_first && (took || busy || chars_pending != 0))) begin
        start <= 1'b0;
      end else begin
        start   <= 1'b1;
        value_i <= number_q[0].value;
        number_q.pop_front();
      end
    end
  end

  // Monitor: predicts on every accepted transaction and checks each strobe.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_pending <= 0;
    end else begin
      if (start && !busy) begin
        push_decimal_text(value_i);
      end
      if (char_valid_o) begin
        if (expected_chars_q.size() == 0) begin
          $display("%0t: unexpected character: code %0d last %0b", $time,
                   char_code_o, last_char_o);
          error_count++;
        end else begin
          want = expected_chars_q.pop_front();
          if (char_code_o !== want.code) begin
            $display("%0t: char_code mismatch: expected %0d actual %0d", $time,
                     want.code, char_code_o);
            error_count++;
          end
          if (last_char_o !== want.last) begin
            $display("%0t: last_char mismatch: expected %0b actual %0b", $time,
                     want.last, last_char_o);
            error_count++;
          end
        end
      end
      chars_pending <= expected_chars_q.size();
    end
  end

  // Stimulus and end of test.
  initial begin
    logic [31:0] directed_vals [$];
    number_item_t item;
    int unsigned  idx;
    int unsigned  digits;
    int unsigned  low_mag;
    int unsigned  high_mag;
    int unsigned  mag;

    // Zero, ones, digit-count boundaries, the extremes and bit patterns.
    directed_vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10,
                      32'd99, 32'd100, -32'sd9, 32'd999999999, 32'd1000000000,
                      -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0001, 32'd1234567890, -32'sd1234567890,
                      32'h5555_5555, 32'hAAAA_AAAA, 32'd4294967286};
    total_numbers = directed_vals.size() + NumRandom;

    foreach (directed_vals[i]) begin
      item.value = directed_vals[i];
      item.gap = (i % 3 == 2) ? $urandom_range(12, 1) : 0;
      item.drain_first = 1'b0;
      number_q.push_back(item);
    end

    for (int n = 0; n < NumRandom; n++) begin
      idx = directed_vals.size() + n;
      case ($urandom_range(9, 0))
        0, 1, 2, 3: item.value = $urandom;
        4, 5, 6, 7: begin
          // Magnitude with a chosen number of digits and a random sign.
          digits = $urandom_range(10, 1);
          low_mag = 1;
          repeat (digits - 1) low_mag = low_mag * 10;
          high_mag = (digits == 10) ? 32'h7FFF_FFFF : low_mag * 10 - 1;
          if (digits == 1) low_mag = 0;
          mag = $urandom_range(high_mag, low_mag);
          item.value = $urandom_range(1, 0) ? (32'd0 - mag) : mag;
        end
        8: item.value = 32'($urandom_range(40, 0)) - 32'd20;
        default: begin
          item.value = $urandom_range(1, 0) ? 32'h8000_0000 + $urandom_range(3, 0)
                                            : 32'h7FFF_FFFF - $urandom_range(3, 0);
        end
      endcase
      // Random idle bursts, none in the quiet tail of the run.
      item.gap = 0;
      if (idx < total_numbers - QuietTail && $urandom_range(2, 0) == 0) begin
        item.gap = $urandom_range(12, 1);
      end
      item.drain_first = (n == 0 || n == NumRandom / 2);
      number_q.push_back(item);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_count != total_numbers) @(posedge clk_i);
    while (chars_pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (expected_chars_q.size() != 0) begin
      $display("%0t: characters never seen: expected %0d actual 0", $time,
               expected_chars_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #5ms;
    $display("%0t: timeout", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sitoa_pkg.sv
rtl/sitoa_cell.sv
rtl/sitoa_chain.sv
rtl/signed_int_to_decimal_ascii_top.sv
test/signed_int_to_decimal_ascii_top_tb.sv
